### src/hfd_pkg.sv
// Package: shared types and constants of the Huffman tree-walk decoder.
package hfd_pkg;

    localparam int MAX_NODES = 512;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int SYM_W     = 8;
    localparam int OP_W      = 2;
    localparam int BIT_CNT_W = 3;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [SYM_W-1:0]   END_SYMBOL_RST = SYM_W'(3);
    localparam logic [NODE_AW-1:0] ROOT_RST       = '0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_DECODE  = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic {
        REG_ROOT = 1'b0,
        REG_END  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CUR,
        ST_STEP,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic               leaf;
        logic [SYM_W-1:0]   symbol;
        logic [NODE_AW-1:0] left;
        logic [NODE_AW-1:0] right;
    } node_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             symbol_valid;
        logic             end_seen;
    } result_t;

    typedef struct packed {
        logic wr_node;
        logic restart;
        logic start;
        logic rd_walk;
        logic use_rd;
        logic rd_hit;
        logic eval;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic ended;
        logic cur_ok;
        logic he_leaf;
        logic he_end;
        logic pend_valid;
        logic slot_free;
        logic last_bit;
    } sts_t;

endpackage

### src/hfd_if.sv
// Interfaces: input item channel and result channel with valid/ready handshake.
interface hfd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [8:0] node_index;
    logic       node_is_leaf;
    logic [7:0] node_symbol;
    logic [8:0] left_index;
    logic [8:0] right_index;
    logic [7:0] code_byte;

    modport source (
        output valid, op, node_index, node_is_leaf, node_symbol,
               left_index, right_index, code_byte,
        input  ready
    );
    modport sink (
        input  valid, op, node_index, node_is_leaf, node_symbol,
               left_index, right_index, code_byte,
        output ready
    );
endinterface

interface hfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       end_seen;
    logic       last;

    modport source (
        output valid, symbol, symbol_valid, end_seen, last,
        input  ready
    );
    modport sink (
        input  valid, symbol, symbol_valid, end_seen, last,
        output ready
    );
endinterface

### src/hfd_ctrl.sv
// Controller: state machine sequencing node writes, restarts and the bit-by-bit walk.
module hfd_ctrl
    import hfd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] in_op,
    output logic            in_ready,
    input  sts_t            sts,
    output cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;
    logic   stall;

    assign stall = sts.he_leaf && sts.pend_valid && !sts.slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (op_t'(in_op) == OP_DECODE) && !sts.ended)
                begin
                    state_next = sts.cur_ok ? ST_STEP : ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_CUR;
            ST_CUR:   state_next = ST_EVAL;
            ST_STEP:  state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (!stall)
                begin
                    if (sts.he_end || sts.last_bit)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (sts.he_leaf)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pend_valid || sts.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr_node = (op_t'(in_op) == OP_WRITE);
                    cmd.restart = (op_t'(in_op) == OP_RESTART);
                    cmd.start   = (op_t'(in_op) == OP_DECODE) && !sts.ended;
                end
            end
            ST_FETCH:
            begin
                cmd.rd_walk = 1'b1;
            end
            ST_CUR:
            begin
                cmd.use_rd = 1'b1;
                cmd.rd_hit = 1'b1;
            end
            ST_STEP:
            begin
                cmd.rd_hit = 1'b1;
            end
            ST_EVAL:
            begin
                cmd.eval = !stall;
            end
            ST_FLUSH:
            begin
                cmd.flush = sts.pend_valid && sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### src/hfd_dp.sv
// Datapath: node table, walk registers, pending result and output register.
module hfd_dp
    import hfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [NODE_AW-1:0] root_index,
    input  logic [SYM_W-1:0]   end_symbol,
    input  logic [NODE_AW-1:0] wr_index,
    input  node_t              wr_node,
    input  logic [7:0]         code_byte,
    hfd_out_if.source          dout
);

    node_t mem [MAX_NODES];
    node_t rd_reg;

    logic [NODE_AW-1:0]   walk_reg, walk_next;
    logic                 ended_reg, ended_next;
    logic                 cur_ok_reg, cur_ok_next;
    node_t                cur_reg, cur_next;
    logic [NODE_AW-1:0]   hit_reg, hit_next;
    logic [7:0]           byte_reg, byte_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic                 out_last_reg, out_last_next;

    node_t              cur;
    logic [NODE_AW-1:0] hit;
    logic [NODE_AW-1:0] rd_addr;
    logic               rd_en;
    logic               he_end;
    logic               slot_free;
    result_t            new_res;

    assign cur     = cmd.use_rd ? rd_reg : cur_reg;
    assign hit     = cur.leaf ? walk_reg : (byte_reg[7] ? cur.right : cur.left);
    assign rd_addr = cmd.rd_walk ? walk_reg : hit;
    assign rd_en   = cmd.rd_walk || cmd.rd_hit;
    assign he_end  = rd_reg.leaf && (rd_reg.symbol == end_symbol);
    assign slot_free = !out_valid_reg || dout.ready;

    always_comb
    begin
        if (he_end)
        begin
            new_res = '{symbol: '0, symbol_valid: 1'b0, end_seen: 1'b1};
        end
        else
        begin
            new_res = '{symbol: rd_reg.symbol, symbol_valid: 1'b1, end_seen: 1'b0};
        end
    end

    assign sts.ended      = ended_reg;
    assign sts.cur_ok     = cur_ok_reg;
    assign sts.he_leaf    = rd_reg.leaf;
    assign sts.he_end     = he_end;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.slot_free  = slot_free;
    assign sts.last_bit   = (cnt_reg == {BIT_CNT_W{1'b1}});

    always_ff @(posedge clk)
    begin
        if (cmd.wr_node)
        begin
            mem[wr_index] <= wr_node;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        walk_next       = walk_reg;
        ended_next      = ended_reg;
        cur_ok_next     = cur_ok_reg;
        cur_next        = cur_reg;
        hit_next        = hit_reg;
        byte_next       = byte_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !dout.ready;

        if (cmd.wr_node)
        begin
            cur_ok_next = 1'b0;
        end
        if (cmd.restart)
        begin
            walk_next   = root_index;
            ended_next  = 1'b0;
            cur_ok_next = 1'b0;
        end
        if (cmd.start)
        begin
            byte_next = code_byte;
            cnt_next  = '0;
        end
        if (cmd.use_rd)
        begin
            cur_next    = rd_reg;
            cur_ok_next = 1'b1;
        end
        if (cmd.rd_hit)
        begin
            hit_next = hit;
        end
        if (cmd.eval)
        begin
            if (rd_reg.leaf)
            begin
                if (pend_valid_reg)
                begin
                    out_next       = pend_reg;
                    out_last_next  = 1'b0;
                    out_valid_next = 1'b1;
                end
                pend_next       = new_res;
                pend_valid_next = 1'b1;
                if (he_end)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    walk_next   = root_index;
                    cur_ok_next = 1'b0;
                end
            end
            else
            begin
                walk_next   = hit_reg;
                cur_next    = rd_reg;
                cur_ok_next = 1'b1;
            end
            byte_next = {byte_reg[6:0], 1'b0};
            cnt_next  = cnt_reg + BIT_CNT_W'(1);
        end
        if (cmd.flush)
        begin
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= ROOT_RST;
            ended_reg      <= 1'b0;
            cur_ok_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            walk_reg       <= walk_next;
            ended_reg      <= ended_next;
            cur_ok_reg     <= cur_ok_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        hit_reg      <= hit_next;
        byte_reg     <= byte_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign dout.valid        = out_valid_reg;
    assign dout.symbol       = out_reg.symbol;
    assign dout.symbol_valid = out_reg.symbol_valid;
    assign dout.end_seen     = out_reg.end_seen;
    assign dout.last         = out_last_reg;

endmodule

### src/huffman_tree_walk_decoder.sv
// Top level: Huffman tree-walk decoder with APB register port.
//
// Usage: software first writes tree nodes (op write) into the 512-entry node
// table, sets root_index and end_symbol over the APB port, then issues a
// restart beat and feeds code bytes (op decode) on din. Each code byte is
// walked most significant bit first; every leaf reached yields one beat on
// dout carrying its symbol, and reaching the end symbol yields one beat with
// symbol_valid low and end_seen high, after which decode beats are dropped
// until the next restart. The final beat caused by a code byte has last high;
// a byte that reaches no leaf causes no beat.
// Sequence: a node write, a restart or a dropped decode is taken in the idle
// state. A code byte passes an accept state, then per bit whose node is held
// a step and an evaluate state, and per bit whose node must first be
// fetched (after a leaf, a restart or a node write; each bit is one dependent
// read of the registered node-table port) a fetch, a current-node and an
// evaluate state, and last a flush state; the end symbol stops the byte.
// Reset clears the walk to node 0, clears the end state, root_index to 0 and
// end_symbol to 3; the node table holds no reset value. When dout stalls,
// one result waits in the output register and one more is held inside;
// the walk then halts until the output register drains.
module huffman_tree_walk_decoder
    import hfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    hfd_in_if.sink            din,
    hfd_out_if.source         dout,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [NODE_AW-1:0] root_reg;
    logic [SYM_W-1:0]   end_sym_reg;
    logic               wr_en;
    reg_idx_t           reg_idx;
    cmd_t               cmd;
    sts_t               sts;
    node_t              wr_node;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg    <= ROOT_RST;
            end_sym_reg <= END_SYMBOL_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROOT: root_reg    <= pwdata[NODE_AW-1:0];
                REG_END:  end_sym_reg <= pwdata[SYM_W-1:0];
                default:  root_reg    <= root_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROOT: prdata = APB_DW'(root_reg);
            REG_END:  prdata = APB_DW'(end_sym_reg);
            default:  prdata = '0;
        endcase
    end

    assign wr_node = '{leaf:   din.node_is_leaf,
                       symbol: din.node_symbol,
                       left:   din.left_index,
                       right:  din.right_index};

    hfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_op    (din.op),
        .in_ready (din.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hfd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .root_index (root_reg),
        .end_symbol (end_sym_reg),
        .wr_index   (din.node_index),
        .wr_node    (wr_node),
        .code_byte  (din.code_byte),
        .dout       (dout)
    );

endmodule

### test/tb.sv
// Testbench for the Huffman tree-walk decoder: random trees and code streams, checked beat by beat.
module tb;
    import hfd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 26;

    typedef struct {
        op_t                op;
        logic [NODE_AW-1:0] node_index;
        logic               node_is_leaf;
        logic [SYM_W-1:0]   node_symbol;
        logic [NODE_AW-1:0] left_index;
        logic [NODE_AW-1:0] right_index;
        logic [7:0]         code_byte;
    } code_item_t;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             symbol_valid;
        logic             end_seen;
        logic             last;
    } sym_beat_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    hfd_in_if  din_bus ();
    hfd_out_if dout_bus ();

    huffman_tree_walk_decoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_bus),
        .dout    (dout_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    node_t              node_table [MAX_NODES];
    logic [NODE_AW-1:0] walk_at = '0;
    logic               walk_ended = 1'b0;
    logic [NODE_AW-1:0] root_sel = ROOT_RST;
    logic [SYM_W-1:0]   end_sym = END_SYMBOL_RST;

    code_item_t pend_items [$];
    sym_beat_t  pending_symbols [$];
    int         tree_set [$];
    code_item_t cur_item;

    int   items_pushed = 0;
    int   items_accepted = 0;
    int   symbols_checked = 0;
    int   ends_checked = 0;
    int   settings_used = 0;
    int   error_count = 0;
    int   quiet_cycles = 0;
    int   in_gap = 0;
    int   out_stall = 0;
    logic in_taken = 1'b0;
    bit   calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void decode_item(input code_item_t it);
        sym_beat_t          beats [$];
        sym_beat_t          b;
        node_t              cur;
        node_t              hit_node;
        logic [NODE_AW-1:0] hit;
        logic [7:0]         code_bits;
        int                 i;
        case (it.op)
            OP_WRITE:
                node_table[it.node_index] = {it.node_is_leaf, it.node_symbol,
                                             it.left_index, it.right_index};
            OP_RESTART:
            begin
                walk_at = root_sel;
                walk_ended = 1'b0;
            end
            OP_DECODE:
            begin
                code_bits = it.code_byte;
                for (i = 0; i < 8 && !walk_ended; i++)
                begin
                    cur = node_table[walk_at];
                    if (cur.leaf)
                        hit = walk_at;
                    else if (code_bits[7])
                        hit = cur.right;
                    else
                        hit = cur.left;
                    hit_node = node_table[hit];
                    if (!hit_node.leaf)
                        walk_at = hit;
                    else if (hit_node.symbol == end_sym)
                    begin
                        walk_ended = 1'b1;
                        b = '{8'h00, 1'b0, 1'b1, 1'b0};
                        beats.insert(beats.size(), b);
                    end
                    else
                    begin
                        b = '{hit_node.symbol, 1'b1, walk_ended, 1'b0};
                        beats.insert(beats.size(), b);
                        walk_at = root_sel;
                    end
                    code_bits = code_bits << 1;
                end
            end
            default: ;
        endcase
        if (beats.size() > 0)
            beats[beats.size() - 1].last = 1'b1;
        foreach (beats[j])
            pending_symbols.insert(pending_symbols.size(), beats[j]);
    endfunction

    // Drive the input channel: hold a beat until taken, then idle or present the next.
    always @(negedge clk)
    begin : drive_in
        code_item_t nxt;
        if (rst_n && (!din_bus.valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                din_bus.valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pend_items.size() > 0)
            begin
                nxt = pend_items.pop_front();
                cur_item <= nxt;
                din_bus.op <= nxt.op;
                din_bus.node_index <= nxt.node_index;
                din_bus.node_is_leaf <= nxt.node_is_leaf;
                din_bus.node_symbol <= nxt.node_symbol;
                din_bus.left_index <= nxt.left_index;
                din_bus.right_index <= nxt.right_index;
                din_bus.code_byte <= nxt.code_byte;
                din_bus.valid <= 1'b1;
                in_gap <= idle_gap();
            end
            else
                din_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            dout_bus.ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
        begin
            dout_bus.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                out_stall <= idle_gap();
        end
    end

    always @(posedge clk)
    begin : watch_beats
        sym_beat_t want;
        if (rst_n)
        begin
            in_taken <= din_bus.valid && din_bus.ready;
            if (din_bus.valid && din_bus.ready)
            begin
                decode_item(cur_item);
                items_accepted++;
            end
            if (dout_bus.valid && dout_bus.ready)
            begin
                if (pending_symbols.size() == 0)
                begin
                    $display("%0t: unexpected beat sym=%02h sv=%0b end=%0b last=%0b", $time,
                             dout_bus.symbol, dout_bus.symbol_valid, dout_bus.end_seen,
                             dout_bus.last);
                    error_count++;
                end
                else
                begin
                    want = pending_symbols.pop_front();
                    if (dout_bus.symbol !== want.symbol
                        || dout_bus.symbol_valid !== want.symbol_valid
                        || dout_bus.end_seen !== want.end_seen
                        || dout_bus.last !== want.last)
                    begin
                        $display("%0t: mismatch expected sym=%02h sv=%0b end=%0b last=%0b",
                                 $time, want.symbol, want.symbol_valid, want.end_seen,
                                 want.last);
                        $display("%0t:          actual   sym=%02h sv=%0b end=%0b last=%0b",
                                 $time, dout_bus.symbol, dout_bus.symbol_valid,
                                 dout_bus.end_seen, dout_bus.last);
                        error_count++;
                    end
                    if (want.symbol_valid)
                        symbols_checked++;
                    else
                        ends_checked++;
                end
            end
            if ((din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic code_item_t random_item(input op_t op);
        code_item_t it;
        it.op = op;
        it.node_index = NODE_AW'($urandom_range(0, MAX_NODES - 1));
        it.node_is_leaf = 1'($urandom_range(0, 1));
        it.node_symbol = SYM_W'($urandom_range(0, 255));
        it.left_index = NODE_AW'($urandom_range(0, MAX_NODES - 1));
        it.right_index = NODE_AW'($urandom_range(0, MAX_NODES - 1));
        it.code_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic send(input code_item_t it);
        pend_items.insert(pend_items.size(), it);
        items_pushed++;
    endtask

    task automatic put_node(input int idx, input bit leaf, input int sym, input int lft,
                            input int rgt);
        code_item_t it;
        it = random_item(OP_WRITE);
        it.node_index = NODE_AW'(idx);
        it.node_is_leaf = leaf;
        it.node_symbol = SYM_W'(sym);
        it.left_index = NODE_AW'(lft);
        it.right_index = NODE_AW'(rgt);
        send(it);
    endtask

    task automatic send_op(input op_t op, input int code);
        code_item_t it;
        it = random_item(op);
        it.code_byte = 8'(code);
        send(it);
    endtask

    // Leaves first, then pair subtrees at random; the last inner node (or a lone leaf) lands on the root.
    task automatic build_tree(input int root, input int nleaves, input bit with_end,
                              input int end_s);
        bit used [MAX_NODES];
        int pool [$];
        int a, b, idx, k, pos;
        tree_set.delete();
        used[root] = 1'b1;
        for (k = 0; k < nleaves; k++)
        begin
            idx = root;
            if (nleaves > 1)
            begin
                do
                    idx = $urandom_range(0, MAX_NODES - 1);
                while (used[idx]);
                used[idx] = 1'b1;
            end
            put_node(idx, 1'b1, (with_end && k == 0) ? end_s : $urandom_range(0, 255),
                     $urandom_range(0, MAX_NODES - 1), $urandom_range(0, MAX_NODES - 1));
            pool.insert(pool.size(), idx);
            tree_set.insert(tree_set.size(), idx);
        end
        while (pool.size() > 1)
        begin
            pos = $urandom_range(0, pool.size() - 1);
            a = pool[pos];
            pool.delete(pos);
            pos = $urandom_range(0, pool.size() - 1);
            b = pool[pos];
            pool.delete(pos);
            idx = root;
            if (pool.size() > 0)
            begin
                do
                    idx = $urandom_range(0, MAX_NODES - 1);
                while (used[idx]);
                used[idx] = 1'b1;
            end
            put_node(idx, 1'b0, $urandom_range(0, 255), a, b);
            pool.insert(pool.size(), idx);
            tree_set.insert(tree_set.size(), idx);
        end
    endtask

    task automatic drain();
        while (items_accepted != items_pushed || pending_symbols.size() != 0)
            @(negedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input reg_idx_t which, input int value);
        logic [APB_DW-1:0] rd;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = APB_AW'(4 * int'(which));
        pwdata = APB_DW'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (rd !== APB_DW'(value))
        begin
            $display("%0t: register %s readback expected %0h actual %0h", $time,
                     which.name(), value, rd);
            error_count++;
        end
        if (which == REG_ROOT)
            root_sel = NODE_AW'(value);
        else
            end_sym = SYM_W'(value);
        settings_used++;
    endtask

    initial
    begin
        code_item_t it;
        int ph, k, r, pos, root_pick, end_pick, nleaves;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        din_bus.valid = 1'b0;
        din_bus.op = OP_WRITE;
        din_bus.node_index = '0;
        din_bus.node_is_leaf = 1'b0;
        din_bus.node_symbol = '0;
        din_bus.left_index = '0;
        din_bus.right_index = '0;
        din_bus.code_byte = '0;
        dout_bus.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // codes: 0 -> 00, 10 -> A5, 110 -> end, 111 loops in place
        cfg_write(REG_ROOT, MAX_NODES - 1);
        cfg_write(REG_END, 255);
        put_node(0, 1'b1, 8'h00, MAX_NODES - 1, MAX_NODES - 1);
        put_node(1, 1'b1, 8'hA5, 0, 0);
        put_node(MAX_NODES - 2, 1'b1, 8'hFF, 0, MAX_NODES - 1);
        put_node(257, 1'b0, 8'h5A, MAX_NODES - 2, 257);
        put_node(256, 1'b0, 8'hFF, 1, 257);
        put_node(MAX_NODES - 1, 1'b0, 8'h00, 0, 256);
        send_op(OP_RESTART, 8'h00);
        send_op(OP_DECODE, 8'h00);
        send_op(OP_DECODE, 8'hAA);
        send_op(OP_DECODE, 8'h80);
        send_op(OP_DECODE, 8'hFF);
        send_op(OP_DECODE, 8'h00);
        send_op(OP_DECODE, 8'h00);
        it = '{OP_NONE, '1, 1'b1, '1, '1, '1, '1};
        send(it);
        send_op(OP_RESTART, 8'hFF);
        send_op(OP_DECODE, 8'h7F);
        send_op(OP_DECODE, 8'hC5);
        send_op(OP_RESTART, 8'h00);
        send_op(OP_DECODE, 8'h40);
        settle();

        // root that is itself a leaf
        cfg_write(REG_ROOT, 5);
        cfg_write(REG_END, 0);
        put_node(5, 1'b1, 8'h5A, 0, 0);
        send_op(OP_RESTART, 8'h00);
        send_op(OP_DECODE, 8'h3C);
        put_node(5, 1'b1, 8'h00, MAX_NODES - 1, 0);
        send_op(OP_DECODE, 8'hC3);
        send_op(OP_DECODE, 8'h55);
        send_op(OP_RESTART, 8'h00);
        send_op(OP_DECODE, 8'h01);

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            case (ph % 3)
                0: root_pick = 0;
                1: root_pick = MAX_NODES - 1;
                default: root_pick = $urandom_range(1, MAX_NODES - 2);
            endcase
            case (ph % 4)
                0: end_pick = 255;
                1: end_pick = 0;
                2: end_pick = 3;
                default: end_pick = $urandom_range(1, 254);
            endcase
            cfg_write(REG_ROOT, root_pick);
            cfg_write(REG_END, end_pick);
            calm = (ph % 4 == 2);
            nleaves = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14);
            build_tree(root_pick, nleaves, $urandom_range(0, 3) != 0, end_pick);
            if (ph == 0 || $urandom_range(0, 4) != 0)
                send_op(OP_RESTART, 8'h00);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    drain();
                r = $urandom_range(0, 99);
                if (r < 72)
                begin
                    it = random_item(OP_DECODE);
                    if (r < 4)
                        it.code_byte = 8'h00;
                    else if (r < 8)
                        it.code_byte = 8'hFF;
                    send(it);
                end
                else if (r < 84)
                    send(random_item(OP_RESTART));
                else if (r < 90)
                begin
                    it = random_item(OP_WRITE);
                    pos = $urandom_range(0, tree_set.size() - 1);
                    it.node_index = NODE_AW'(tree_set[pos]);
                    if (!it.node_is_leaf)
                    begin
                        pos = $urandom_range(0, tree_set.size() - 1);
                        it.left_index = NODE_AW'(tree_set[pos]);
                        pos = $urandom_range(0, tree_set.size() - 1);
                        it.right_index = NODE_AW'(tree_set[pos]);
                    end
                    send(it);
                end
                else if (r < 95)
                begin
                    it = random_item(OP_WRITE);
                    it.node_is_leaf = 1'b1;
                    send(it);
                end
                else
                    send(random_item(OP_NONE));
            end
        end
        settle();

        $display("Run covered %0d input beats across %0d register writes.", items_accepted,
                 settings_used);
        $display("Checked %0d decoded symbols and %0d end-of-text beats.", symbols_checked,
                 ends_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
